@@ rtl/position_drift_monitor_assert.svh @@
// Assertion macros for the position drift monitor checkers.
`ifndef POSITION_DRIFT_MONITOR_ASSERT_SVH
`define POSITION_DRIFT_MONITOR_ASSERT_SVH

// Clocked check, off while reset is held.
`define PDM_CHECK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked check, active through reset.
`define PDM_CHECK_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/pdm_pkg.sv @@
`default_nettype none
package pdm_pkg;

    localparam int EVENT_DEPTH    = 32;
    localparam int WAYPOINT_DEPTH = 32;
    localparam int EV_IDX_W = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
    localparam int WP_IDX_W = (WAYPOINT_DEPTH > 1) ? $clog2(WAYPOINT_DEPTH) : 1;
    localparam int EV_FILL_W = $clog2(EVENT_DEPTH + 1);
    localparam int WP_FILL_W = $clog2(WAYPOINT_DEPTH + 1);

    localparam logic [2:0] MODE_START     = 3'd0;
    localparam logic [2:0] MODE_STOP      = 3'd1;
    localparam logic [2:0] MODE_SAMPLE    = 3'd2;
    localparam logic [2:0] MODE_WP_ADD    = 3'd3;
    localparam logic [2:0] MODE_WP_READ   = 3'd4;
    localparam logic [2:0] MODE_EV_READ   = 3'd5;
    localparam logic [2:0] MODE_WP_CLEAR  = 3'd6;
    localparam logic [2:0] MODE_EV_CLEAR  = 3'd7;

    localparam logic [1:0] STATUS_DONE    = 2'd0;
    localparam logic [1:0] STATUS_IGNORED = 2'd1;
    localparam logic [1:0] STATUS_BAD     = 2'd2;

    localparam logic [1:0] SEV_MINOR    = 2'd0;
    localparam logic [1:0] SEV_MODERATE = 2'd1;
    localparam logic [1:0] SEV_SEVERE   = 2'd2;
    localparam logic [1:0] SEV_NONE     = 2'd3;

    localparam int CFG_INDEX_W = 4;
    localparam logic [CFG_INDEX_W-1:0] REG_MINOR    = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MODERATE = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SEVERE   = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_INTERVAL = 4'd3;

    localparam logic [31:0] INTERVAL_FLOOR = 32'd50;

    typedef struct packed {
        logic [31:0]        etime;
        logic signed [31:0] expected;
        logic signed [31:0] actual;
        logic signed [31:0] error;
        logic [1:0]         level;
    } event_entry_t;

    typedef struct packed {
        logic [31:0]        etime;
        logic signed [31:0] encoder;
        logic signed [31:0] motor;
        logic signed [31:0] drift;
    } waypoint_entry_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] drift_value;
        logic [1:0]         severity;
        logic [31:0]        entry_time;
        logic signed [31:0] entry_motor;
        logic signed [31:0] entry_encoder;
        logic [30:0]        max_drift;
        logic [31:0]        total_distance;
        logic [31:0]        cumulative_drift;
        logic signed [31:0] peak_velocity;
        logic [15:0]        correction_total;
        logic [7:0]         entry_count;
    } result_t;

    function automatic logic signed [31:0] sat33(input logic signed [32:0] x);
        if (x[32] != x[31]) begin
            sat33 = x[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            sat33 = x[31:0];
        end
    endfunction

    function automatic logic [32:0] abs33(input logic signed [32:0] x);
        abs33 = x[32] ? 33'(-x) : 33'(x);
    endfunction

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [32:0] b);
        logic [33:0] s;
        s = {2'b00, a} + {1'b0, b};
        sat_add32 = (s[33:32] != 2'b00) ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage
`default_nettype wire

@@ rtl/position_drift_monitor.sv @@
`default_nettype none
// Position drift monitor. One request per cycle is taken on s_* unless m_ready
// stalls the output; each gives one result on m_* through the input register
// (with the registered log read) and the result register, one result per cycle
// while m_ready is high. The drift, statistics and log-write arithmetic for a
// request is finished in the cycle it is accepted; waypoint and event logs are
// memories read at read_index. Configuration writes on cfg_* are always taken.
module position_drift_monitor (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            cfg_valid,
    output logic                           cfg_ready,
    input  wire [pdm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire [31:0]                     cfg_data,
    input  wire                            s_valid,
    output logic                           s_ready,
    input  wire [2:0]                      s_mode,
    input  wire [31:0]                     s_now_ms,
    input  wire signed [31:0]              s_encoder_pos,
    input  wire signed [31:0]              s_motor_a_pos,
    input  wire signed [31:0]              s_motor_b_pos,
    input  wire signed [31:0]              s_encoder_velocity,
    input  wire [15:0]                     s_correction_events,
    input  wire [7:0]                      s_read_index,
    output logic                           m_valid,
    input  wire                            m_ready,
    output logic [1:0]                     m_status,
    output logic signed [31:0]             m_drift_value,
    output logic [1:0]                     m_severity,
    output logic [31:0]                    m_entry_time,
    output logic signed [31:0]             m_entry_motor,
    output logic signed [31:0]             m_entry_encoder,
    output logic [30:0]                    m_max_drift,
    output logic [31:0]                    m_total_distance,
    output logic [31:0]                    m_cumulative_drift,
    output logic signed [31:0]             m_peak_velocity,
    output logic [15:0]                    m_correction_total,
    output logic [7:0]                     m_entry_count
);
    import pdm_pkg::*;

    localparam logic [1:0] SEL_BASE = 2'd0;
    localparam logic [1:0] SEL_WP   = 2'd1;
    localparam logic [1:0] SEL_EV   = 2'd2;

    logic [30:0] minor_reg, moderate_reg, severe_reg;
    logic [31:0] interval_reg;

    logic                 active_reg, active_next;
    logic [31:0]          start_reg, start_next;
    logic [31:0]          last_ms_reg, last_ms_next;
    logic signed [31:0]   last_enc_reg, last_enc_next;
    logic signed [31:0]   last_drift_reg, last_drift_next;
    logic [31:0]          dsum_reg, dsum_next;
    logic [30:0]          dpeak_reg, dpeak_next;
    logic [31:0]          dist_reg, dist_next;
    logic signed [31:0]   vpeak_reg, vpeak_next;
    logic [15:0]          cbase_reg, cbase_next;
    logic [15:0]          csum_reg, csum_next;
    logic [EV_FILL_W-1:0] ev_fill_reg, ev_fill_next;
    logic [WP_FILL_W-1:0] wp_fill_reg, wp_fill_next;

    event_entry_t    ev_mem [EVENT_DEPTH];
    waypoint_entry_t wp_mem [WAYPOINT_DEPTH];
    event_entry_t    ev_wdata, ev_rd_reg;
    waypoint_entry_t wp_wdata, wp_rd_reg;
    logic            ev_we, wp_we;

    logic    a_valid_reg;
    logic [1:0] a_sel_reg, sel_next;
    result_t a_res_reg, res_next, out_reg, out_next;
    logic    m_valid_reg;
    logic    accept, advance;

    logic [32:0]        abs_a, abs_b, amag, delta, moved;
    logic signed [31:0] motor_sel, drift, wp_drift;
    logic [30:0]        capped;
    logic [16:0]        csum_wide;
    logic [31:0]        elapsed;
    logic [1:0]         sev;
    logic               wp_count;
    logic               have_time;

    assign cfg_ready = 1'b1;
    assign advance   = a_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !a_valid_reg || advance;
    assign accept    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            minor_reg    <= 31'd128;
            moderate_reg <= 31'd384;
            severe_reg   <= 31'd768;
            interval_reg <= 32'd200;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_MINOR:    minor_reg    <= cfg_data[30:0];
                REG_MODERATE: moderate_reg <= cfg_data[30:0];
                REG_SEVERE:   severe_reg   <= cfg_data[30:0];
                REG_INTERVAL: interval_reg <= (cfg_data < INTERVAL_FLOOR) ?
                                              INTERVAL_FLOOR : cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        abs_a     = abs33({s_motor_a_pos[31], s_motor_a_pos});
        abs_b     = abs33({s_motor_b_pos[31], s_motor_b_pos});
        motor_sel = (abs_a > abs_b) ? s_motor_a_pos : s_motor_b_pos;
        drift     = sat33({s_encoder_pos[31], s_encoder_pos} - {motor_sel[31], motor_sel});
        amag      = abs33({drift[31], drift});
        delta     = abs33({drift[31], drift} - {last_drift_reg[31], last_drift_reg});
        moved     = abs33({s_encoder_pos[31], s_encoder_pos}
                          - {last_enc_reg[31], last_enc_reg});
        capped    = (amag > 33'h0_7FFF_FFFF) ? 31'h7FFF_FFFF : amag[30:0];
        csum_wide = {1'b0, csum_reg} + {1'b0, s_correction_events - cbase_reg};
        wp_drift  = sat33({s_encoder_pos[31], s_encoder_pos}
                          - {s_motor_a_pos[31], s_motor_a_pos});
        elapsed   = s_now_ms - start_reg;
        if (amag >= {2'b00, severe_reg}) begin
            sev = SEV_SEVERE;
        end else if (amag >= {2'b00, moderate_reg}) begin
            sev = SEV_MODERATE;
        end else begin
            sev = SEV_MINOR;
        end

        active_next     = active_reg;
        start_next      = start_reg;
        last_ms_next    = last_ms_reg;
        last_enc_next   = last_enc_reg;
        last_drift_next = last_drift_reg;
        dsum_next       = dsum_reg;
        dpeak_next      = dpeak_reg;
        dist_next       = dist_reg;
        vpeak_next      = vpeak_reg;
        cbase_next      = cbase_reg;
        csum_next       = csum_reg;
        ev_fill_next    = ev_fill_reg;
        wp_fill_next    = wp_fill_reg;
        ev_we           = 1'b0;
        wp_we           = 1'b0;
        ev_wdata        = '{etime: elapsed, expected: s_motor_a_pos, actual: s_encoder_pos,
                            error: drift, level: sev};
        wp_wdata        = '{etime: elapsed, encoder: s_encoder_pos, motor: s_motor_a_pos,
                            drift: wp_drift};
        sel_next        = SEL_BASE;
        wp_count        = 1'b0;
        have_time       = 1'b0;
        res_next        = '0;
        res_next.severity = SEV_NONE;
        res_next.status   = STATUS_DONE;

        unique case (s_mode)
            MODE_START: begin
                if (active_reg) begin
                    res_next.status = STATUS_IGNORED;
                end else begin
                    active_next     = 1'b1;
                    start_next      = s_now_ms;
                    last_ms_next    = s_now_ms;
                    last_enc_next   = s_encoder_pos;
                    last_drift_next = '0;
                    dsum_next       = '0;
                    dpeak_next      = '0;
                    dist_next       = '0;
                    vpeak_next      = '0;
                    cbase_next      = s_correction_events;
                    csum_next       = '0;
                    ev_fill_next    = '0;
                    wp_fill_next    = '0;
                end
            end
            MODE_STOP: begin
                if (!active_reg) begin
                    res_next.status = STATUS_IGNORED;
                end else begin
                    active_next = 1'b0;
                end
            end
            MODE_SAMPLE: begin
                if (!active_reg || (s_now_ms - last_ms_reg) < interval_reg) begin
                    res_next.status = STATUS_IGNORED;
                end else begin
                    last_ms_next    = s_now_ms;
                    dsum_next       = sat_add32(dsum_reg, delta);
                    last_drift_next = drift;
                    if (s_encoder_velocity > vpeak_reg) begin
                        vpeak_next = s_encoder_velocity;
                    end
                    if (capped > dpeak_reg) begin
                        dpeak_next = capped;
                    end
                    dist_next     = sat_add32(dist_reg, moved);
                    last_enc_next = s_encoder_pos;
                    if (s_correction_events > cbase_reg) begin
                        csum_next  = csum_wide[16] ? 16'hFFFF : csum_wide[15:0];
                        cbase_next = s_correction_events;
                    end
                    res_next.drift_value = drift;
                    if (amag >= {2'b00, minor_reg}) begin
                        res_next.severity = sev;
                        if (ev_fill_reg < EV_FILL_W'(EVENT_DEPTH)) begin
                            ev_we        = 1'b1;
                            ev_fill_next = ev_fill_reg + 1'b1;
                        end
                    end
                end
            end
            MODE_WP_ADD: begin
                wp_count = 1'b1;
                if (wp_fill_reg >= WP_FILL_W'(WAYPOINT_DEPTH)) begin
                    res_next.status = STATUS_BAD;
                end else begin
                    wp_we                  = 1'b1;
                    wp_fill_next           = wp_fill_reg + 1'b1;
                    have_time              = 1'b1;
                    res_next.entry_time    = elapsed;
                    res_next.entry_encoder = s_encoder_pos;
                    res_next.entry_motor   = s_motor_a_pos;
                    res_next.drift_value   = wp_drift;
                end
            end
            MODE_WP_READ: begin
                wp_count  = 1'b1;
                have_time = 1'b1;
                if (s_read_index >= 8'(wp_fill_reg)) begin
                    res_next.status = STATUS_BAD;
                end else begin
                    sel_next = SEL_WP;
                end
            end
            MODE_EV_READ: begin
                have_time = 1'b1;
                if (s_read_index >= 8'(ev_fill_reg)) begin
                    res_next.status = STATUS_BAD;
                end else begin
                    sel_next = SEL_EV;
                end
            end
            MODE_WP_CLEAR: begin
                wp_count     = 1'b1;
                wp_fill_next = '0;
            end
            MODE_EV_CLEAR: begin
                ev_fill_next = '0;
            end
            default: ;
        endcase

        if (!have_time) begin
            res_next.entry_time = active_next ? (s_now_ms - start_next) : 32'd0;
        end
        res_next.max_drift        = dpeak_next;
        res_next.total_distance   = dist_next;
        res_next.cumulative_drift = dsum_next;
        res_next.peak_velocity    = vpeak_next;
        res_next.correction_total = csum_next;
        res_next.entry_count      = wp_count ? 8'(wp_fill_next) : 8'(ev_fill_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg     <= 1'b0;
            start_reg      <= '0;
            last_ms_reg    <= '0;
            last_enc_reg   <= '0;
            last_drift_reg <= '0;
            dsum_reg       <= '0;
            dpeak_reg      <= '0;
            dist_reg       <= '0;
            vpeak_reg      <= '0;
            cbase_reg      <= '0;
            csum_reg       <= '0;
            ev_fill_reg    <= '0;
            wp_fill_reg    <= '0;
        end else if (accept) begin
            active_reg     <= active_next;
            start_reg      <= start_next;
            last_ms_reg    <= last_ms_next;
            last_enc_reg   <= last_enc_next;
            last_drift_reg <= last_drift_next;
            dsum_reg       <= dsum_next;
            dpeak_reg      <= dpeak_next;
            dist_reg       <= dist_next;
            vpeak_reg      <= vpeak_next;
            cbase_reg      <= cbase_next;
            csum_reg       <= csum_next;
            ev_fill_reg    <= ev_fill_next;
            wp_fill_reg    <= wp_fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && ev_we) begin
            ev_mem[ev_fill_reg[EV_IDX_W-1:0]] <= ev_wdata;
        end
        if (accept && wp_we) begin
            wp_mem[wp_fill_reg[WP_IDX_W-1:0]] <= wp_wdata;
        end
        if (accept) begin
            ev_rd_reg <= ev_mem[s_read_index[EV_IDX_W-1:0]];
            wp_rd_reg <= wp_mem[s_read_index[WP_IDX_W-1:0]];
            a_res_reg <= res_next;
            a_sel_reg <= sel_next;
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

    always_comb begin
        out_next = a_res_reg;
        unique case (a_sel_reg)
            SEL_WP: begin
                out_next.entry_time    = wp_rd_reg.etime;
                out_next.entry_encoder = wp_rd_reg.encoder;
                out_next.entry_motor   = wp_rd_reg.motor;
                out_next.drift_value   = wp_rd_reg.drift;
            end
            SEL_EV: begin
                out_next.entry_time    = ev_rd_reg.etime;
                out_next.entry_motor   = ev_rd_reg.expected;
                out_next.entry_encoder = ev_rd_reg.actual;
                out_next.drift_value   = ev_rd_reg.error;
                out_next.severity      = ev_rd_reg.level;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                a_valid_reg <= 1'b1;
            end else if (advance) begin
                a_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_status           = out_reg.status;
    assign m_drift_value      = out_reg.drift_value;
    assign m_severity         = out_reg.severity;
    assign m_entry_time       = out_reg.entry_time;
    assign m_entry_motor      = out_reg.entry_motor;
    assign m_entry_encoder    = out_reg.entry_encoder;
    assign m_max_drift        = out_reg.max_drift;
    assign m_total_distance   = out_reg.total_distance;
    assign m_cumulative_drift = out_reg.cumulative_drift;
    assign m_peak_velocity    = out_reg.peak_velocity;
    assign m_correction_total = out_reg.correction_total;
    assign m_entry_count      = out_reg.entry_count;

endmodule
`default_nettype wire

@@ rtl/pdm_checker.sv @@
`default_nettype none
`include "position_drift_monitor_assert.svh"
module pdm_checker (
    input wire               aclk,
    input wire               aresetn,
    input wire               m_valid,
    input wire               m_ready,
    input wire [1:0]         m_status,
    input wire signed [31:0] m_drift_value,
    input wire [1:0]         m_severity,
    input wire signed [31:0] m_entry_motor,
    input wire signed [31:0] m_entry_encoder
);
    import pdm_pkg::*;

    `PDM_CHECK(a_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_drift_value), "result dropped or changed while stalled")
    `PDM_CHECK(a_status_code, aclk, aresetn, m_valid |-> m_status != 2'd3, "undefined status code")
    `PDM_CHECK(a_bad_zero, aclk, aresetn, m_valid && m_status == STATUS_BAD |-> m_drift_value == 0 && m_entry_motor == 0 && m_entry_encoder == 0, "rejected request carries entry data")
    `PDM_CHECK(a_bad_sev, aclk, aresetn, m_valid && m_status != STATUS_DONE |-> m_severity == SEV_NONE, "rejected request carries a severity")

endmodule

bind position_drift_monitor pdm_checker u_pdm_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_status        (m_status),
    .m_drift_value   (m_drift_value),
    .m_severity      (m_severity),
    .m_entry_motor   (m_entry_motor),
    .m_entry_encoder (m_entry_encoder)
);
`default_nettype wire
